// ===== design/sme_pkg.sv =====
`default_nettype none
package sme_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_POP  = 4'd5,
    OP_DUP  = 4'd6,
    OP_SWAP = 4'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_SKIPPED  = 3'd5
  } status_t;

  function automatic logic [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Q16.16 product back to Q16.16, truncated toward zero
  function automatic logic [31:0] mul_sat(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd65535 : 64'sd0);
    return sat64(t >>> 16);
  endfunction

endpackage
`default_nettype wire

// ===== design/stack_machine_executor.sv =====
// Sequence from accept to result: skipped, faulting, push and pop pass S_TOP,
//   S_TOPW; the rest read (S_RDB, S_RDA), execute (S_EXEC) and write back; mul adds
//   S_MUL2, div S_DIV (24 radix-4 steps) and S_DIVFIX; a zero divisor goes to S_TOP.
// Throughput: one request at a time; the next is taken after the result is taken.
// Reset (rst, synchronous) empties the stack and clears the held fault; stack contents
//   are not cleared.
`default_nettype none
module stack_machine_executor
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         op,
  input  wire logic signed [31:0] push_value,
  input  wire logic               program_start,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              status,
  output logic signed [31:0]      top_value,
  output logic [5:0]              depth
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DIV_STEPS = 24;
  localparam int CW = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_RDB, S_RDA, S_EXEC, S_MUL2, S_DIV, S_DIVFIX,
    S_WR1, S_WR2, S_TOP, S_TOPW, S_OUT
  } state_t;

  state_t state;
  logic [DW-1:0] sp;
  logic held;
  logic [3:0] opr;
  status_t stat;
  logic [31:0] opb, res;
  logic signed [63:0] prod;
  logic [31:0] rem, dvs;
  logic [47:0] dvd;
  logic neg;
  logic [CW-1:0] cnt;

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata;
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic [DW-1:0] am1, am2;
  logic full;

  logic [31:0] rem_next;
  logic [47:0] dvd_next;
  logic [32:0] r2;
  logic [32:0] sum;
  logic [31:0] mag_a, mag_b;
  logic signed [63:0] qs;

  assign in_ready = (state == S_IDLE);
  assign depth = 6'(sp);
  assign am1 = sp - DW'(1);
  assign am2 = sp - DW'(2);
  assign full = (sp == DW'(STACK_DEPTH));
  assign mag_a = rdata[31] ? (32'd0 - rdata) : rdata;
  assign mag_b = opb[31] ? (32'd0 - opb) : opb;
  assign sum = (opr == OP_SUB) ? ({rdata[31], rdata} - {opb[31], opb})
                               : ({rdata[31], rdata} + {opb[31], opb});
  assign qs = neg ? -$signed({16'd0, dvd}) : $signed({16'd0, dvd});

  always_comb begin
    rem_next = rem;
    dvd_next = dvd;
    r2 = '0;
    for (int i = 0; i < 2; i++) begin
      r2 = {rem_next, dvd_next[47]};
      dvd_next = {dvd_next[46:0], 1'b0};
      if (r2 >= {1'b0, dvs}) begin
        r2 = r2 - {1'b0, dvs};
        dvd_next[0] = 1'b1;
      end
      rem_next = r2[31:0];
    end
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = am1[AW-1:0];
    wr_en = 1'b0;
    wr_addr = sp[AW-1:0];
    wr_data = res;
    case (state)
      S_IDLE: begin
        wr_en = in_valid && (op == OP_PUSH) && !full && !(held && !program_start);
        wr_data = push_value;
      end
      S_RDB, S_TOP: rd_en = 1'b1;
      S_RDA: begin
        rd_en = 1'b1;
        rd_addr = am2[AW-1:0];
      end
      S_EXEC: begin
        wr_en = (opr == OP_SWAP);
        wr_addr = am1[AW-1:0];
        wr_data = rdata;
      end
      S_WR1: begin
        wr_en = 1'b1;
        wr_addr = (opr == OP_DUP) ? sp[AW-1:0] : am2[AW-1:0];
      end
      S_WR2: begin
        wr_en = 1'b1;
        wr_addr = am2[AW-1:0];
        wr_data = opb;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp <= '0;
      held <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            opr <= op;
            stat <= ST_OK;
            state <= S_TOP;
            if (held && !program_start) begin
              stat <= ST_SKIPPED;
            end else begin
              held <= 1'b0;
              case (op)
                OP_PUSH: begin
                  if (full) begin
                    stat <= ST_OVERFLOW;
                    held <= 1'b1;
                  end else sp <= sp + DW'(1);
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
                  if (sp < DW'(2)) begin
                    stat <= ST_UNDERFLOW;
                    held <= 1'b1;
                  end else state <= S_RDB;
                end
                OP_POP: begin
                  if (sp == '0) begin
                    stat <= ST_UNDERFLOW;
                    held <= 1'b1;
                  end else sp <= am1;
                end
                OP_DUP: begin
                  if (sp == '0) begin
                    stat <= ST_UNDERFLOW;
                    held <= 1'b1;
                  end else if (full) begin
                    stat <= ST_OVERFLOW;
                    held <= 1'b1;
                  end else state <= S_RDB;
                end
                default: begin
                  stat <= ST_UNKNOWN;
                  held <= 1'b1;
                end
              endcase
            end
          end
        end
        S_RDB: state <= S_RDA;
        S_RDA: begin
          opb <= rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          case (opr)
            OP_DUP: begin
              res <= opb;
              state <= S_WR1;
            end
            OP_SWAP: state <= S_WR2;
            OP_MUL: begin
              prod <= $signed(rdata) * $signed(opb);
              state <= S_MUL2;
            end
            OP_DIV: begin
              if (opb == '0) begin
                stat <= ST_DIVZERO;
                held <= 1'b1;
                sp <= am2;
                state <= S_TOP;
              end else begin
                rem <= '0;
                dvd <= {mag_a, 16'd0};
                dvs <= mag_b;
                neg <= rdata[31] ^ opb[31];
                cnt <= '0;
                state <= S_DIV;
              end
            end
            default: begin
              res <= sat64(64'(signed'(sum)));
              state <= S_WR1;
            end
          endcase
        end
        S_MUL2: begin
          res <= mul_sat(prod);
          state <= S_WR1;
        end
        S_DIV: begin
          rem <= rem_next;
          dvd <= dvd_next;
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DIV_STEPS - 1)) state <= S_DIVFIX;
        end
        S_DIVFIX: begin
          res <= sat64(qs);
          state <= S_WR1;
        end
        S_WR1: begin
          sp <= (opr == OP_DUP) ? sp + DW'(1) : am1;
          state <= S_TOP;
        end
        S_WR2: state <= S_TOP;
        S_TOP: state <= S_TOPW;
        S_TOPW: begin
          top_value <= (sp == '0) ? 32'sd0 : $signed(rdata);
          status <= stat;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/sme_checker.sv =====
`default_nettype none
module sme_checker
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2:0]         status,
  input wire logic signed [31:0] top_value,
  input wire logic [5:0]         depth
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(top_value)
      && $stable(depth)) else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_SKIPPED) else $error("bad status code");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    (STACK_DEPTH < 64) && out_valid && depth == 6'd0 |-> top_value == 32'sd0)
    else $error("empty stack with nonzero top");

  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

endmodule

bind stack_machine_executor sme_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sme_checker (.*);
`default_nettype wire
